// ===== design/rvm_pkg.sv =====
package rvm_pkg;

   localparam int REG_COUNT  = 16;
   localparam int MEM_WORDS  = 1024;
   localparam int STACK_STEP = 1;
   localparam int CODE_STEP  = 1;
   localparam int REG_AW     = $clog2(REG_COUNT);
   localparam int MEM_AW     = $clog2(MEM_WORDS);
   localparam int WORD_W     = 32;
   localparam int IP_W       = 16;

   typedef enum logic [4:0] {
      OP_RET    = 5'd0,
      OP_CALL   = 5'd1,
      OP_JMP    = 5'd2,
      OP_LOADI  = 5'd3,
      OP_LOAD   = 5'd4,
      OP_LOADB  = 5'd5,
      OP_STORE  = 5'd6,
      OP_STOREB = 5'd7,
      OP_POP    = 5'd8,
      OP_PUSH   = 5'd9,
      OP_JT     = 5'd10,
      OP_JF     = 5'd11,
      OP_ADD    = 5'd12,
      OP_SUB    = 5'd13,
      OP_MUL    = 5'd14,
      OP_DIV    = 5'd15,
      OP_MOV    = 5'd16,
      OP_NOT    = 5'd17,
      OP_EQ     = 5'd18,
      OP_LT     = 5'd19,
      OP_LE     = 5'd20
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request and read the operands
      logic mem_issue;   // start the memory access (read or write)
      logic div_start;   // start the iterative divider
      logic mul_start;   // start the multiplier
      logic commit;      // update architectural state and output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic mul_done;
   } stat_type;

endpackage

// ===== design/rvm_ram.sv =====
module rvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== design/rvm_ctrl.sv =====
module rvm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [4:0]       req_action,
   output rvm_pkg::cmd_type cmd,
   input  rvm_pkg::stat_type stat
);
   import rvm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_MEM, S_DIV, S_MUL, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   op_type    op_ff, op_in;
   logic      accept;

   // A new request enters only when no instruction is in flight and the output
   // register is free or being emptied in this cycle.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               op_in       = op_type'(req_action);
               state_in    = S_READ;
            end
         end
         S_READ: begin
            case (op_ff)
               OP_RET, OP_CALL, OP_LOAD, OP_LOADB, OP_STORE, OP_STOREB,
               OP_POP, OP_PUSH: begin
                  cmd.mem_issue = 1'b1;
                  state_in      = S_MEM;
               end
               OP_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
               OP_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_in      = S_MUL;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_MEM: state_in = S_DONE;
         S_DIV: if (stat.div_done) state_in = S_DONE;
         S_MUL: if (stat.mul_done) state_in = S_DONE;
         S_DONE: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_RET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mem_issue, cmd.div_start, cmd.mul_start, cmd.commit}))
      else $error("controller issued two commands at once");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not raise the response");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request accepted while busy");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || rsp_ready)
      else $error("commit would overwrite a pending response");
endmodule

// ===== design/rvm_dp.sv =====
module rvm_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  rvm_pkg::cmd_type                cmd,
   output rvm_pkg::stat_type               stat,
   input  logic [4:0]                      req_action,
   input  logic [3:0]                      req_dst_reg,
   input  logic [3:0]                      req_first_reg,
   input  logic [3:0]                      req_second_reg,
   input  logic signed [31:0]              req_literal,
   input  logic [15:0]                     req_target,
   output logic [15:0]                     rsp_next_ip,
   output logic                            rsp_ip_changed,
   output logic                            rsp_fault,
   output logic signed [31:0]              rsp_written_value
);
   import rvm_pkg::*;

   logic [WORD_W-1:0] rf_ff [REG_COUNT];
   logic [MEM_AW-1:0] sp_ff;
   logic [IP_W-1:0]   ip_ff;

   op_type            op_ff;
   logic [REG_AW-1:0] dst_ff;
   logic [WORD_W-1:0] a_ff, b_ff, lit_ff;
   logic [IP_W-1:0]   tgt_ff;

   logic [IP_W-1:0]   seq;
   logic [MEM_AW-1:0] sp_dec, sp_inc, mem_addr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;
   logic              mem_we;

   assign seq    = ip_ff + IP_W'(CODE_STEP);
   assign sp_dec = sp_ff - MEM_AW'(STACK_STEP);
   assign sp_inc = sp_ff + MEM_AW'(STACK_STEP);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_action);
         dst_ff <= REG_AW'(req_dst_reg);
         a_ff   <= rf_ff[REG_AW'(req_first_reg)];
         b_ff   <= rf_ff[REG_AW'(req_second_reg)];
         lit_ff <= req_literal;
         tgt_ff <= req_target;
      end
   end

   always_comb begin
      mem_addr  = MEM_AW'(lit_ff);
      mem_wdata = a_ff;
      mem_we    = 1'b0;
      case (op_ff)
         OP_RET, OP_POP: mem_addr = sp_inc;
         OP_CALL: begin
            mem_addr  = sp_ff;
            mem_wdata = WORD_W'(seq);
            mem_we    = cmd.mem_issue;
         end
         OP_PUSH: begin
            mem_addr = sp_ff;
            mem_we   = cmd.mem_issue;
         end
         OP_LOADB: mem_addr = MEM_AW'(lit_ff + b_ff);
         OP_STORE: mem_we = cmd.mem_issue;
         OP_STOREB: begin
            mem_addr = MEM_AW'(lit_ff + b_ff);
            mem_we   = cmd.mem_issue;
         end
         default: ;
      endcase
   end

   rvm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Multiplier: operands registered, one 32x32 low product, then registered.
   logic [WORD_W-1:0] prod_ff;
   logic              mul_done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= cmd.mul_start;
      end
      if (cmd.mul_start) begin
         prod_ff <= a_ff * b_ff;
      end
   end

   // Restoring divider on magnitudes, one quotient bit per cycle.
   logic [WORD_W-1:0] dvd_ff, dvs_ff, quo_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [5:0]        cnt_ff;
   logic              neg_ff, div_busy_ff, div_done_ff;
   logic [WORD_W:0]   rem_sh, rem_sub;
   assign rem_sh  = {rem_ff, dvd_ff[WORD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
            cnt_ff      <= 6'(WORD_W);
            rem_ff      <= '0;
            quo_ff      <= '0;
            dvd_ff      <= a_ff[WORD_W-1] ? -a_ff : a_ff;
            dvs_ff      <= b_ff[WORD_W-1] ? -b_ff : b_ff;
            neg_ff      <= a_ff[WORD_W-1] ^ b_ff[WORD_W-1];
         end else if (div_busy_ff) begin
            dvd_ff <= {dvd_ff[WORD_W-2:0], 1'b0};
            if (!rem_sub[WORD_W]) begin
               rem_ff <= rem_sub[WORD_W-1:0];
               quo_ff <= {quo_ff[WORD_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[WORD_W-1:0];
               quo_ff <= {quo_ff[WORD_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.div_done = div_done_ff;
   assign stat.mul_done = mul_done_ff;

   logic [WORD_W-1:0] wv, diff;
   logic [IP_W-1:0]   nip;
   logic              chg, flt, wreg, lt;
   assign diff = a_ff - b_ff;
   assign lt   = (a_ff[WORD_W-1] != b_ff[WORD_W-1]) ? a_ff[WORD_W-1] : diff[WORD_W-1];

   always_comb begin
      wv   = '0;
      nip  = seq;
      chg  = 1'b0;
      flt  = 1'b0;
      wreg = 1'b0;
      case (op_ff)
         OP_RET: begin
            nip = mem_rdata[IP_W-1:0];
            chg = 1'b1;
         end
         OP_CALL: begin
            wv  = WORD_W'(seq);
            nip = tgt_ff;
            chg = 1'b1;
         end
         OP_JMP: begin
            nip = tgt_ff;
            chg = 1'b1;
         end
         OP_LOADI: begin wv = lit_ff; wreg = 1'b1; end
         OP_LOAD, OP_LOADB, OP_POP: begin wv = mem_rdata; wreg = 1'b1; end
         OP_STORE, OP_STOREB, OP_PUSH: wv = a_ff;
         OP_JT: if (a_ff != '0) begin nip = tgt_ff; chg = 1'b1; end
         OP_JF: if (a_ff == '0) begin nip = tgt_ff; chg = 1'b1; end
         OP_ADD: begin wv = a_ff + b_ff; wreg = 1'b1; end
         OP_SUB: begin wv = diff; wreg = 1'b1; end
         OP_MUL: begin wv = prod_ff; wreg = 1'b1; end
         OP_DIV: begin
            wreg = 1'b1;
            if (b_ff == '0) begin
               flt = 1'b1;
            end else begin
               wv = neg_ff ? -quo_ff : quo_ff;
            end
         end
         OP_MOV: begin wv = a_ff; wreg = 1'b1; end
         OP_NOT: begin wv = WORD_W'(a_ff == '0); wreg = 1'b1; end
         OP_EQ:  begin wv = WORD_W'(a_ff == b_ff); wreg = 1'b1; end
         OP_LT:  begin wv = WORD_W'(lt); wreg = 1'b1; end
         OP_LE:  begin wv = WORD_W'(lt || (a_ff == b_ff)); wreg = 1'b1; end
         default: flt = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= '0;
         end
         sp_ff <= MEM_AW'(MEM_WORDS - 1);
         ip_ff <= '0;
      end else if (cmd.commit) begin
         if (wreg) begin
            rf_ff[dst_ff] <= wv;
         end
         if (op_ff inside {OP_CALL, OP_PUSH}) begin
            sp_ff <= sp_dec;
         end else if (op_ff inside {OP_RET, OP_POP}) begin
            sp_ff <= sp_inc;
         end
         ip_ff <= nip;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_next_ip       <= nip;
         rsp_ip_changed    <= chg;
         rsp_fault         <= flt;
         rsp_written_value <= wv;
      end
   end

   a_div_excl: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !cmd.commit)
      else $error("commit while divider busy");
   a_ip_follow: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> ip_ff == rsp_next_ip)
      else $error("instruction pointer differs from reported next_ip");
   a_sp_push: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_PUSH) |=> sp_ff == $past(sp_dec))
      else $error("push did not lower the stack pointer");
endmodule

// ===== design/register_vm_execute_unit.sv =====
// Execute unit for a small register virtual machine.
// The req_ channel carries one decoded instruction per request: action, register
// indexes, a signed literal and a code target. The rsp_ channel returns one
// result per request: next instruction pointer, a control-change flag, a fault
// flag and the value that was written. Both channels use valid/ready.
// On acceptance the operands are read. Register and jump operations then
// go straight to the result; memory and stack operations use the single
// memory port with a registered read, multiply forms a registered product,
// and divide runs a restoring divider one quotient bit per cycle. The result
// is then written to the output register and rsp_valid is raised.
// One instruction is in flight at a time; the next request is taken once the
// controller is idle and the output register is empty or is being emptied in
// the same cycle.
// Reset clears the registers, sets the stack pointer to the top word and the
// instruction pointer to zero; the data memory is not cleared. While the
// receiver stalls, the result is held in the output register and no new
// request is accepted.
module register_vm_execute_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_action,
   input  logic [3:0]         req_dst_reg,
   input  logic [3:0]         req_first_reg,
   input  logic [3:0]         req_second_reg,
   input  logic signed [31:0] req_literal,
   input  logic [15:0]        req_target,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_next_ip,
   output logic               rsp_ip_changed,
   output logic               rsp_fault,
   output logic signed [31:0] rsp_written_value
);
   import rvm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences each instruction; the datapath holds the architectural state.
   rvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .req_action (req_action),
      .cmd        (cmd),
      .stat       (stat)
   );

   rvm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_dst_reg       (req_dst_reg),
      .req_first_reg     (req_first_reg),
      .req_second_reg    (req_second_reg),
      .req_literal       (req_literal),
      .req_target        (req_target),
      .rsp_next_ip       (rsp_next_ip),
      .rsp_ip_changed    (rsp_ip_changed),
      .rsp_fault         (rsp_fault),
      .rsp_written_value (rsp_written_value)
   );
endmodule
